@@ hdl/page_frame_allocator_refcount_core_assert.svh @@
// ----------------------------------------------------------------------------
// page frame allocator assertion macros
// clocked property wrappers used by page_frame_allocator_refcount_core
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_ALLOCATOR_REFCOUNT_CORE_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_REFCOUNT_CORE_ASSERT_SVH

// same-cycle implication
`define PFA_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/pfa_pkg.sv @@
// ----------------------------------------------------------------------------
// pfa_pkg
// commands, status codes, register indexes, register reset values and sequencer states
// ----------------------------------------------------------------------------
package pfa_pkg;

    typedef enum logic [1:0] {
        CMD_ALLOC    = 2'd0,
        CMD_ADD_REF  = 2'd1,
        CMD_DROP_REF = 2'd2,
        CMD_REBUILD  = 2'd3
    } cmd_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    localparam logic [2:0] REG_TOTAL_FRAMES  = 3'd0;
    localparam logic [2:0] REG_HOLE_FIRST    = 3'd1;
    localparam logic [2:0] REG_HOLE_LAST     = 3'd2;
    localparam logic [2:0] REG_KERNEL_FIRST  = 3'd3;
    localparam logic [2:0] REG_KERNEL_LAST   = 3'd4;

    localparam logic [12:0] TOTAL_FRAMES_RST = 13'd4096;
    localparam logic [11:0] HOLE_FIRST_RST   = 12'd159;
    localparam logic [11:0] HOLE_LAST_RST    = 12'd256;
    localparam logic [11:0] KERNEL_FIRST_RST = 12'd512;
    localparam logic [11:0] KERNEL_LAST_RST  = 12'd1023;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_STK,
        S_ALLOC_REF,
        S_REF_WAIT,
        S_REBUILD
    } state_t;

endpackage

@@ hdl/pfa_ram.sv @@
// ----------------------------------------------------------------------------
// pfa_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module pfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        rdata_reg <= mem_array[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/page_frame_allocator_refcount_core.sv @@
// ----------------------------------------------------------------------------
// page_frame_allocator_refcount_core
// free frame stack and per-frame reference counts held in two rams
// ----------------------------------------------------------------------------
// alloc: busy (stack read, then count read), done in the cycle after
// add / drop reference: busy (count read, then write back), done after
// empty alloc or bad frame: answered in the cycle after start, never busy
// rebuild: sets counts below lim, stacks unreserved frames; lim = frame limit
// reset clears the stack depth and loads register defaults; rams are not cleared
// results are strobed on done for one cycle, the receiver cannot stall
module page_frame_allocator_refcount_core
    import pfa_pkg::*;
#(
    parameter int NUM_FRAMES = 4096,
    parameter int REF_BITS   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [11:0] frame_number,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data,
    output logic        done,
    output logic [1:0]  status,
    output logic [11:0] result_frame,
    output logic [15:0] ref_after,
    output logic [12:0] frames_free
);

    localparam int FW = $clog2(NUM_FRAMES);
    localparam int DW = $clog2(NUM_FRAMES + 1);
    localparam logic [DW-1:0]       DEPTH_MAX = DW'(NUM_FRAMES);
    localparam logic [REF_BITS-1:0] COUNT_MAX = '1;
    localparam logic [REF_BITS-1:0] COUNT_ONE = REF_BITS'(1);

    // configuration
    logic [12:0] total_frames_reg;
    logic [11:0] hole_first_reg;
    logic [11:0] hole_last_reg;
    logic [11:0] kernel_first_reg;
    logic [11:0] kernel_last_reg;

    state_t state_reg, state_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [DW-1:0] idx_reg, idx_next;
    cmd_t          cmd_reg, cmd_next;
    logic [11:0]   frame_reg, frame_next;
    logic [FW-1:0] pop_reg, pop_next;

    logic          done_reg, done_next;
    logic [1:0]    status_reg, status_next;
    logic [FW-1:0] rframe_reg, rframe_next;
    logic [REF_BITS-1:0] rcount_reg, rcount_next;
    logic [DW-1:0] rfree_reg, rfree_next;

    logic                ref_we;
    logic [FW-1:0]       ref_waddr, ref_raddr;
    logic [REF_BITS-1:0] ref_wdata, ref_rdata;
    logic                stk_we;
    logic [FW-1:0]       stk_waddr, stk_raddr, stk_wdata, stk_rdata;

    logic [DW-1:0] lim;
    logic [31:0]   tf_wide;
    logic [DW-1:0] depth_dec;
    logic [FW+11:0] in_frame_ext, reg_frame_ext;
    logic [FW-1:0] in_idx, reg_idx;
    logic          in_bad;
    logic          walk_end;
    logic          walk_rsv;
    logic [31:0]   walk_wide;
    logic          depth_room;
    logic [FW+11:0] out_frame_ext;
    logic [REF_BITS+15:0] out_count_ext;
    logic [DW+12:0] out_free_ext;

    // frame limit and index conversions
    assign tf_wide   = {19'd0, total_frames_reg};
    assign lim       = (tf_wide > 32'(NUM_FRAMES)) ? DEPTH_MAX : DW'(tf_wide);
    assign depth_dec = depth_reg - DW'(1);
    assign depth_room = depth_reg < DEPTH_MAX;

    assign in_frame_ext  = {{FW{1'b0}}, frame_number};
    assign in_idx        = in_frame_ext[FW-1:0];
    assign reg_frame_ext = {{FW{1'b0}}, frame_reg};
    assign reg_idx       = reg_frame_ext[FW-1:0];
    assign in_bad        = {20'd0, frame_number} >= 32'(lim);

    assign walk_end  = idx_reg == lim;
    assign walk_wide = 32'(idx_reg);
    assign walk_rsv  =
        ((hole_first_reg <= hole_last_reg) &&
         (walk_wide >= {20'd0, hole_first_reg}) &&
         (walk_wide <= {20'd0, hole_last_reg})) ||
        ((kernel_first_reg <= kernel_last_reg) &&
         (walk_wide >= {20'd0, kernel_first_reg}) &&
         (walk_wide <= {20'd0, kernel_last_reg}));

    pfa_ram #(
        .WIDTH (REF_BITS),
        .DEPTH (NUM_FRAMES),
        .AW    (FW)
    ) u_ref_ram (
        .clk   (clk),
        .we    (ref_we),
        .waddr (ref_waddr),
        .wdata (ref_wdata),
        .raddr (ref_raddr),
        .rdata (ref_rdata)
    );

    pfa_ram #(
        .WIDTH (FW),
        .DEPTH (NUM_FRAMES),
        .AW    (FW)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd_t'(cmd))
                        CMD_REBUILD:  state_next = S_REBUILD;
                        CMD_ALLOC:    state_next = (depth_reg == '0) ? S_IDLE : S_ALLOC_STK;
                        CMD_ADD_REF,
                        CMD_DROP_REF: state_next = in_bad ? S_IDLE : S_REF_WAIT;
                    endcase
                end
            end
            S_ALLOC_STK: state_next = S_ALLOC_REF;
            S_ALLOC_REF: state_next = S_IDLE;
            S_REF_WAIT:  state_next = S_IDLE;
            S_REBUILD:   state_next = walk_end ? S_IDLE : S_REBUILD;
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath, memory controls and results
    always_comb
    begin
        depth_next  = depth_reg;
        idx_next    = idx_reg;
        cmd_next    = cmd_reg;
        frame_next  = frame_reg;
        pop_next    = pop_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        rframe_next = rframe_reg;
        rcount_next = rcount_reg;
        rfree_next  = rfree_reg;
        ref_we      = 1'b0;
        ref_waddr   = reg_idx;
        ref_wdata   = ref_rdata;
        ref_raddr   = in_idx;
        stk_we      = 1'b0;
        stk_waddr   = depth_reg[FW-1:0];
        stk_wdata   = reg_idx;
        stk_raddr   = depth_dec[FW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd_t'(cmd);
                    frame_next = frame_number;
                    unique case (cmd_t'(cmd))
                        CMD_REBUILD:
                        begin
                            depth_next = '0;
                            idx_next   = '0;
                        end
                        CMD_ALLOC:
                        begin
                            if (depth_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                                rframe_next = '0;
                                rcount_next = '0;
                                rfree_next  = depth_reg;
                            end
                            else
                            begin
                                depth_next = depth_dec;
                            end
                        end
                        CMD_ADD_REF,
                        CMD_DROP_REF:
                        begin
                            if (in_bad)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_BAD;
                                rframe_next = in_idx;
                                rcount_next = '0;
                                rfree_next  = depth_reg;
                            end
                        end
                    endcase
                end
            end
            S_ALLOC_STK:
            begin
                ref_raddr = stk_rdata;
                pop_next  = stk_rdata;
            end
            S_ALLOC_REF:
            begin
                done_next   = 1'b1;
                status_next = ST_OK;
                rframe_next = pop_reg;
                rcount_next = ref_rdata;
                rfree_next  = depth_reg;
            end
            S_REF_WAIT:
            begin
                done_next   = 1'b1;
                rframe_next = reg_idx;
                if (cmd_reg == CMD_ADD_REF)
                begin
                    if (ref_rdata == COUNT_MAX)
                    begin
                        status_next = ST_SAT;
                        rcount_next = ref_rdata;
                    end
                    else
                    begin
                        ref_we      = 1'b1;
                        ref_wdata   = ref_rdata + COUNT_ONE;
                        status_next = ST_OK;
                        rcount_next = ref_rdata + COUNT_ONE;
                    end
                    rfree_next = depth_reg;
                end
                else
                begin
                    if (ref_rdata == '0)
                    begin
                        status_next = ST_BAD;
                        rcount_next = '0;
                        rfree_next  = depth_reg;
                    end
                    else
                    begin
                        ref_we      = 1'b1;
                        ref_wdata   = ref_rdata - COUNT_ONE;
                        status_next = ST_OK;
                        rcount_next = ref_rdata - COUNT_ONE;
                        // last reference gone: back on the stack if it has room
                        if ((ref_rdata == COUNT_ONE) && depth_room)
                        begin
                            stk_we     = 1'b1;
                            depth_next = depth_reg + DW'(1);
                        end
                        rfree_next = depth_next;
                    end
                end
            end
            S_REBUILD:
            begin
                if (walk_end)
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    rframe_next = '0;
                    rcount_next = '0;
                    rfree_next  = depth_reg;
                end
                else
                begin
                    ref_we    = 1'b1;
                    ref_waddr = idx_reg[FW-1:0];
                    ref_wdata = walk_rsv ? COUNT_ONE : '0;
                    if (!walk_rsv)
                    begin
                        stk_we     = 1'b1;
                        stk_wdata  = idx_reg[FW-1:0];
                        depth_next = depth_reg + DW'(1);
                    end
                    idx_next = idx_reg + DW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            depth_reg        <= '0;
            done_reg         <= 1'b0;
            total_frames_reg <= TOTAL_FRAMES_RST;
            hole_first_reg   <= HOLE_FIRST_RST;
            hole_last_reg    <= HOLE_LAST_RST;
            kernel_first_reg <= KERNEL_FIRST_RST;
            kernel_last_reg  <= KERNEL_LAST_RST;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            done_reg  <= done_next;
            if (cfg_write)
            begin
                priority case (cfg_index)
                    REG_TOTAL_FRAMES: total_frames_reg <= cfg_data;
                    REG_HOLE_FIRST:   hole_first_reg   <= cfg_data[11:0];
                    REG_HOLE_LAST:    hole_last_reg    <= cfg_data[11:0];
                    REG_KERNEL_FIRST: kernel_first_reg <= cfg_data[11:0];
                    REG_KERNEL_LAST:  kernel_last_reg  <= cfg_data[11:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        cmd_reg    <= cmd_next;
        frame_reg  <= frame_next;
        pop_reg    <= pop_next;
        status_reg <= status_next;
        rframe_reg <= rframe_next;
        rcount_reg <= rcount_next;
        rfree_reg  <= rfree_next;
    end

    assign out_frame_ext = {12'd0, rframe_reg};
    assign out_count_ext = {16'd0, rcount_reg};
    assign out_free_ext  = {13'd0, rfree_reg};

    assign busy         = state_reg != S_IDLE;
    assign done         = done_reg;
    assign status       = status_reg;
    assign result_frame = out_frame_ext[11:0];
    assign ref_after    = out_count_ext[15:0];
    assign frames_free  = out_free_ext[12:0];

`include "page_frame_allocator_refcount_core_assert.svh"

    `PFA_ASSERT_IMPLY(a_depth_bound, 1'b1, depth_reg <= DEPTH_MAX, "stack depth above frame count")
    `PFA_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done, "accepted item dropped")
    `PFA_ASSERT_IMPLY(a_empty_depth, done && (status == ST_EMPTY), frames_free == 13'd0, "empty with frames")
    `PFA_ASSERT_IMPLY(a_done_idle, done && busy, $past(state_reg == S_IDLE), "result while working")

endmodule
